// ----- hw/rtl/first_fit_free_list_allocator_macros.svh -----
// assertion macros for the allocator checker
// depends on nothing
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
// implication checked on every clock unless in reset
`define FFA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define FFA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- hw/rtl/ffa_pkg.sv -----
// shared types and codes for the first fit free list allocator
// no dependencies
package ffa_pkg;
   localparam int unsigned ADDR_W = 12;
   localparam int unsigned SIZE_W = 13;
   localparam int unsigned BYTES_W = 16;
   // alignment must stay a power of two, the unit count is a shift
   localparam int unsigned ALIGN_BYTES = 8;
   // heap size in units, tied to the address width
   localparam int unsigned HEAP_UNITS = 4096;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE = 2'd1,
      MODE_REALLOC = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_ZERO = 2'd1,
      ST_OOM = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SIZE_RD,
      S_SIZE_WAIT,
      S_DECIDE,
      S_SCAN_RD,
      S_SCAN_SZ,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_BUMP,
      S_FREE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [ADDR_W-1:0] addr;
      logic [BYTES_W-1:0] size_bytes;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result_addr;
      logic [1:0] status;
   } rsp_type;
endpackage

// ----- hw/rtl/ffa_stream_if.sv -----
// valid/ready channel carrying one payload
// depends on nothing
interface ffa_stream_if #(
   parameter int unsigned W = 1
);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/first_fit_free_list_allocator.sv -----
// channel   dir  payload                          handshake
// req       in   mode, addr, size_bytes           valid/ready
// rsp       out  result_addr, status              valid/ready
// csr       in   heap_limit                       write enable
// one transaction at a time; a request walks the free list entry by entry, and
// when a found block is removed the entries above it are moved down one by one;
// the sequencer and the one registered read port of the list memory set this
// pace. reset is synchronous, needs no clearing pass; a held response blocks
// the next request until taken.
// depends on ffa_pkg, ffa_stream_if, ffa_size_ram, ffa_list_ram
module first_fit_free_list_allocator #(
   parameter int unsigned HEADER_UNITS = 2,
   parameter int unsigned FREE_DEPTH = 256
) (
   input  logic clock,
   input  logic reset,
   ffa_stream_if.sink req,
   ffa_stream_if.source rsp,
   input  logic csr_wr_en,
   input  logic [ffa_pkg::SIZE_W-1:0] csr_wr_data
);
   localparam int unsigned LAW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(FREE_DEPTH + 1);
   localparam int unsigned HAW = $clog2(ffa_pkg::HEAP_UNITS);
   localparam int unsigned AL_SH = $clog2(ffa_pkg::ALIGN_BYTES);
   localparam int unsigned UW = ffa_pkg::BYTES_W + 1;
   localparam int unsigned BW = 18;

   ffa_pkg::state_type state_ff, state_in;
   ffa_pkg::req_type req_ff, req_in;
   logic [ffa_pkg::SIZE_W-1:0] limit_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [BW-1:0] brk_ff, brk_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [UW-1:0] units_ff, units_in;
   logic [ffa_pkg::ADDR_W-1:0] cand_ff, cand_in;
   logic [ffa_pkg::ADDR_W-1:0] res_ff, res_in;
   logic [1:0] st_ff, st_in;
   logic free_old_ff, free_old_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic s_we, l_we;
   logic [HAW-1:0] s_waddr, s_raddr;
   logic [ffa_pkg::SIZE_W-1:0] s_wdata, s_rdata;
   logic [LAW-1:0] l_waddr, l_raddr;
   logic [ffa_pkg::ADDR_W-1:0] l_wdata, l_rdata;
   logic [ffa_pkg::ADDR_W-1:0] sz_addr;
   logic sz_in_range;
   logic [BW-1:0] lim_eff, end_val;

   ffa_size_ram #(.DEPTH(ffa_pkg::HEAP_UNITS), .AW(HAW), .DW(ffa_pkg::SIZE_W)) u_size (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr(s_raddr), .rd_data(s_rdata));
   ffa_list_ram #(.DEPTH(FREE_DEPTH), .AW(LAW), .DW(ffa_pkg::ADDR_W)) u_list (
      .clock(clock), .wr_en(l_we), .wr_addr(l_waddr), .wr_data(l_wdata),
      .rd_addr(l_raddr), .rd_data(l_rdata));

   assign lim_eff = (BW'(limit_ff) > BW'(ffa_pkg::HEAP_UNITS)) ?
                    BW'(ffa_pkg::HEAP_UNITS) : BW'(limit_ff);
   assign end_val = brk_ff + BW'(HEADER_UNITS) + BW'(units_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffa_pkg::S_IDLE;
         limit_ff <= ffa_pkg::SIZE_W'(4096);
         count_ff <= '0;
         brk_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         count_ff <= count_in;
         brk_ff <= brk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      units_ff <= units_in;
      cand_ff <= cand_in;
      res_ff <= res_in;
      st_ff <= st_in;
      free_old_ff <= free_old_in;
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      count_in = count_ff;
      brk_in = brk_ff;
      idx_in = idx_ff;
      units_in = units_ff;
      cand_in = cand_ff;
      res_in = res_ff;
      st_in = st_ff;
      free_old_in = free_old_ff;
      rsp_valid_in = rsp_valid_ff;
      s_we = 1'b0;
      s_waddr = brk_ff[HAW-1:0] + HAW'(HEADER_UNITS);
      s_wdata = units_ff[ffa_pkg::SIZE_W-1:0];
      sz_addr = req_ff.addr;
      l_we = 1'b0;
      l_waddr = count_ff[LAW-1:0];
      l_wdata = req_ff.addr;
      l_raddr = idx_ff[LAW-1:0];
      if (state_ff == ffa_pkg::S_SCAN_SZ) begin
         sz_addr = l_rdata;
      end
      s_raddr = sz_addr[HAW-1:0];
      sz_in_range = (32'(sz_addr) < ffa_pkg::HEAP_UNITS);
      case (state_ff)
         ffa_pkg::S_IDLE: begin
            if (req.valid) begin
               req_in = req.data;
               units_in = (UW'(req_in.size_bytes) + UW'(ffa_pkg::ALIGN_BYTES - 1)) >> AL_SH;
               free_old_in = 1'b0;
               state_in = ffa_pkg::S_SIZE_RD;
            end
         end
         ffa_pkg::S_SIZE_RD: state_in = ffa_pkg::S_SIZE_WAIT;
         ffa_pkg::S_SIZE_WAIT: state_in = ffa_pkg::S_DECIDE;
         ffa_pkg::S_DECIDE: begin
            res_in = '0;
            st_in = ffa_pkg::ST_OK;
            idx_in = count_ff;
            state_in = ffa_pkg::S_DONE;
            case (req_ff.mode)
               ffa_pkg::MODE_ALLOC: begin
                  if (req_ff.size_bytes == '0) st_in = ffa_pkg::ST_ZERO;
                  else state_in = ffa_pkg::S_SCAN_RD;
               end
               ffa_pkg::MODE_FREE: state_in = ffa_pkg::S_FREE;
               ffa_pkg::MODE_REALLOC: begin
                  if (req_ff.addr == '0) begin
                     if (req_ff.size_bytes == '0) st_in = ffa_pkg::ST_ZERO;
                     else state_in = ffa_pkg::S_SCAN_RD;
                  end else if (req_ff.size_bytes == '0) begin
                     state_in = ffa_pkg::S_FREE;
                  end else if (sz_in_range && UW'(s_rdata) >= units_ff) begin
                     res_in = req_ff.addr;
                  end else begin
                     free_old_in = 1'b1;
                     state_in = ffa_pkg::S_SCAN_RD;
                  end
               end
               default: ;
            endcase
         end
         ffa_pkg::S_SCAN_RD: begin
            // fetch the entry just below the scan index
            l_raddr = LAW'(idx_ff - CW'(1));
            if (idx_ff == '0) begin
               state_in = ffa_pkg::S_BUMP;
            end else begin
               idx_in = idx_ff - CW'(1);
               state_in = ffa_pkg::S_SCAN_SZ;
            end
         end
         // list entry is on l_rdata, size read launched
         ffa_pkg::S_SCAN_SZ: begin
            cand_in = l_rdata;
            state_in = ffa_pkg::S_SCAN_CMP;
         end
         ffa_pkg::S_SCAN_CMP: begin
            if ((32'(cand_ff) < ffa_pkg::HEAP_UNITS) && UW'(s_rdata) >= units_ff) begin
               res_in = cand_ff;
               count_in = count_ff - CW'(1);
               idx_in = idx_ff + CW'(1);
               state_in = ffa_pkg::S_SHIFT_RD;
            end else begin
               state_in = ffa_pkg::S_SCAN_RD;
            end
         end
         // close the gap: entry j takes entry j+1
         ffa_pkg::S_SHIFT_RD: begin
            if (idx_ff > count_ff) begin
               state_in = free_old_ff ? ffa_pkg::S_FREE : ffa_pkg::S_DONE;
            end else begin
               state_in = ffa_pkg::S_SHIFT_WR;
            end
         end
         ffa_pkg::S_SHIFT_WR: begin
            l_we = 1'b1;
            l_waddr = LAW'(idx_ff - CW'(1));
            l_wdata = l_rdata;
            idx_in = idx_ff + CW'(1);
            state_in = ffa_pkg::S_SHIFT_RD;
         end
         ffa_pkg::S_BUMP: begin
            if (end_val > lim_eff) begin
               res_in = '0;
               st_in = ffa_pkg::ST_OOM;
               state_in = ffa_pkg::S_DONE;
            end else begin
               res_in = ffa_pkg::ADDR_W'(brk_ff + BW'(HEADER_UNITS));
               brk_in = end_val;
               s_we = (brk_ff + BW'(HEADER_UNITS)) < BW'(ffa_pkg::HEAP_UNITS);
               state_in = free_old_ff ? ffa_pkg::S_FREE : ffa_pkg::S_DONE;
            end
         end
         ffa_pkg::S_FREE: begin
            if (req_ff.addr != '0) begin
               if (32'(count_ff) >= FREE_DEPTH) begin
                  st_in = ffa_pkg::ST_FULL;
               end else begin
                  l_we = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            rsp_valid_in = 1'b1;
            state_in = ffa_pkg::S_DONE;
         end
         ffa_pkg::S_DONE: begin
            rsp_valid_in = 1'b1;
            if (rsp_valid_ff && rsp.ready) begin
               rsp_valid_in = 1'b0;
               state_in = ffa_pkg::S_IDLE;
            end
         end
         default: state_in = ffa_pkg::S_IDLE;
      endcase
   end

   assign req.ready = (state_ff == ffa_pkg::S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = {res_ff, st_ff};
endmodule

// ----- hw/rtl/ffa_size_ram.sv -----
// block size table, one write and one registered read port
// depends on nothing
module ffa_size_ram #(
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned AW = 12,
   parameter int unsigned DW = 13
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

// ----- hw/rtl/ffa_list_ram.sv -----
// free list storage, one write and one registered read port
// depends on nothing
module ffa_list_ram #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW = 8,
   parameter int unsigned DW = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

// ----- hw/rtl/ffa_checker.sv -----
// port-level checks for the allocator
// depends on first_fit_free_list_allocator_macros.svh and ffa_pkg
`include "first_fit_free_list_allocator_macros.svh"
module ffa_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [13:0] rsp_data
);
   logic rsp_stall;
   logic rsp_fail;

   assign rsp_stall = rsp_valid && !rsp_ready;
   // zero size and out of heap both return the null address
   assign rsp_fail = rsp_valid && (rsp_data[1:0] == ffa_pkg::ST_ZERO ||
                                   rsp_data[1:0] == ffa_pkg::ST_OOM);

   `FFA_ASSERT_IMP(a_no_req_while_rsp, clock, reset, rsp_valid, !req_ready)
   `FFA_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `FFA_ASSERT_NXT(a_rsp_holds, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `FFA_ASSERT_IMP(a_fail_null, clock, reset, rsp_fail, rsp_data[13:2] == '0)
endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));

// ----- bench/tb_first_fit_free_list_allocator.sv -----
// self-checking testbench for the first fit free list allocator
// depends on ffa_pkg, ffa_stream_if and the allocator rtl; drives bursts of requests
// and checks every response against a shadow model of the heap and free list
module tb_first_fit_free_list_allocator;
   localparam int ALIGN = 8;
   localparam int HDR = 2;
   localparam int HEAP = 4096;
   localparam int LIST_DEPTH = 256;
   localparam int DRAIN_CYCLES = 1500;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [ffa_pkg::SIZE_W-1:0] csr_wr_data = '0;

   ffa_stream_if #(.W($bits(ffa_pkg::req_type))) req_ch ();
   ffa_stream_if #(.W($bits(ffa_pkg::rsp_type))) rsp_ch ();

   first_fit_free_list_allocator u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // shadow heap state
   int unsigned heap_limit_q = HEAP;
   int unsigned free_addr_q [LIST_DEPTH];
   int unsigned free_cnt_q = 0;
   int unsigned brk_q = 0;
   int unsigned block_units [HEAP];
   int unsigned live_blocks [$];
   int unsigned known_blocks [$];

   ffa_pkg::req_type pending_reqs [$];
   ffa_pkg::rsp_type expected_rsps [$];
   int mismatches = 0;
   bit gen_done = 1'b0;

   function automatic int unsigned units_for(int unsigned nbytes);
      return (nbytes + ALIGN - 1) / ALIGN;
   endfunction

   function automatic void drop_live(int unsigned a);
      foreach (live_blocks[k])
         if (live_blocks[k] == a) begin
            live_blocks.delete(k);
            return;
         end
   endfunction

   function automatic int unsigned take_block(int unsigned nbytes,
                                              output ffa_pkg::status_type st);
      int unsigned u, lim, stop, a;
      if (nbytes == 0) begin
         st = ffa_pkg::ST_ZERO;
         return 0;
      end
      u = units_for(nbytes);
      // newest entry first
      for (int i = int'(free_cnt_q) - 1; i >= 0; i--) begin
         a = free_addr_q[i];
         if (block_units[a] >= u) begin
            for (int j = i; j + 1 < int'(free_cnt_q); j++)
               free_addr_q[j] = free_addr_q[j + 1];
            free_cnt_q--;
            st = ffa_pkg::ST_OK;
            live_blocks.push_back(a);
            return a;
         end
      end
      lim = (heap_limit_q > HEAP) ? HEAP : heap_limit_q;
      stop = brk_q + HDR + u;
      if (stop > lim) begin
         st = ffa_pkg::ST_OOM;
         return 0;
      end
      a = brk_q + HDR;
      brk_q = stop;
      block_units[a] = u & 13'h1fff;
      known_blocks.push_back(a);
      live_blocks.push_back(a);
      st = ffa_pkg::ST_OK;
      return a;
   endfunction

   function automatic ffa_pkg::status_type release_block(int unsigned a);
      if (a == 0) return ffa_pkg::ST_OK;
      drop_live(a);
      if (free_cnt_q >= LIST_DEPTH) return ffa_pkg::ST_FULL;
      free_addr_q[free_cnt_q] = a;
      free_cnt_q++;
      return ffa_pkg::ST_OK;
   endfunction

   function automatic ffa_pkg::rsp_type heap_step(ffa_pkg::req_type it);
      ffa_pkg::rsp_type r;
      ffa_pkg::status_type st;
      int unsigned res;
      st = ffa_pkg::ST_OK;
      res = 0;
      case (ffa_pkg::mode_type'(it.mode))
         ffa_pkg::MODE_ALLOC: res = take_block(32'(it.size_bytes), st);
         ffa_pkg::MODE_FREE: st = release_block(32'(it.addr));
         ffa_pkg::MODE_REALLOC: begin
            if (it.addr == '0) res = take_block(32'(it.size_bytes), st);
            else if (it.size_bytes == '0) st = release_block(32'(it.addr));
            else if (units_for(32'(it.size_bytes)) <= block_units[it.addr])
               res = 32'(it.addr);
            else begin
               res = take_block(32'(it.size_bytes), st);
               if (res != 0) st = release_block(32'(it.addr));
            end
         end
         default: ;
      endcase
      r.result_addr = res[ffa_pkg::ADDR_W-1:0];
      r.status = st;
      return r;
   endfunction

   // driver: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      ffa_pkg::req_type nxt;
      logic v;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_rsps.push_back(heap_step(ffa_pkg::req_type'(req_ch.data)));
         if (!(req_ch.valid && !req_ch.ready)) begin
            v = 1'b0;
            nxt = '0;
            if (gap_left > 0) gap_left--;
            else if (pending_reqs.size() > 0) begin
               nxt = pending_reqs.pop_front();
               v = 1'b1;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = int'($urandom_range(1, 24));
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
               end
            end
            req_ch.valid <= v;
            req_ch.data <= nxt;
         end
      end
   end

   // monitor: compare each response transaction with the oldest prediction
   int stall_mode = 0;
   int stall_cnt = 0;
   logic [7:0] stall_pat = 8'hff;
   always @(posedge clock) begin
      ffa_pkg::rsp_type got, want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = ffa_pkg::rsp_type'(rsp_ch.data);
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response addr=%0d status=%0d",
                           got.result_addr, got.status);
            end else begin
               want = expected_rsps.pop_front();
               if (got.result_addr !== want.result_addr || got.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                              want.result_addr, want.status, got.result_addr, got.status);
               end
            end
         end
         stall_cnt++;
         if (stall_cnt % 40 == 0) begin
            stall_mode = int'($urandom_range(0, 2));
            stall_pat = 8'($urandom);
         end
         case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: rsp_ch.ready <= stall_pat[stall_cnt % 8] | stall_pat[(stall_cnt / 8) % 8];
         endcase
      end
   end

   function automatic int unsigned pick_addr();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8 || known_blocks.size() == 0) return 0;
      if (r < 85 && live_blocks.size() > 0)
         return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      return known_blocks[$urandom_range(0, known_blocks.size() - 1)];
   endfunction

   function automatic int unsigned pick_bytes();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 0;
      if (r < 85) return $urandom_range(1, 64);
      if (r < 95) return $urandom_range(65, 2000);
      return $urandom_range(0, 65535);
   endfunction

   function automatic ffa_pkg::req_type make_req(int free_pct);
      ffa_pkg::req_type it;
      int r;
      r = $urandom_range(0, 99);
      it.size_bytes = ffa_pkg::BYTES_W'(pick_bytes());
      if (r < 4) begin
         it.mode = ffa_pkg::MODE_NONE;
         it.addr = ffa_pkg::ADDR_W'($urandom);
         it.size_bytes = ffa_pkg::BYTES_W'($urandom);
      end else if (r < 4 + free_pct) begin
         it.mode = ffa_pkg::MODE_FREE;
         it.addr = ffa_pkg::ADDR_W'(pick_addr());
      end else if (r < 4 + free_pct + (96 - free_pct) / 3) begin
         it.mode = ffa_pkg::MODE_REALLOC;
         it.addr = ffa_pkg::ADDR_W'(pick_addr());
      end else begin
         it.mode = ffa_pkg::MODE_ALLOC;
         it.addr = ffa_pkg::ADDR_W'($urandom);
      end
      return it;
   endfunction

   // sampled away from the rising edge so driver updates have settled
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_one(ffa_pkg::mode_type m, int unsigned a, int unsigned nbytes);
      ffa_pkg::req_type it;
      it.mode = m;
      it.addr = ffa_pkg::ADDR_W'(a);
      it.size_bytes = ffa_pkg::BYTES_W'(nbytes);
      pending_reqs.push_back(it);
      wait_idle();
   endtask

   task automatic write_limit(int unsigned v);
      wait_idle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= ffa_pkg::SIZE_W'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      heap_limit_q = v & 13'h1fff;
   endtask

   task automatic run_random(int n, int free_pct);
      for (int i = 0; i < n; i++) begin
         while (pending_reqs.size() >= 4) @(posedge clock);
         pending_reqs.push_back(make_req(free_pct));
      end
   endtask

   initial begin
      int unsigned a;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_limit(HEAP);
      // directed corner cases
      send_one(ffa_pkg::MODE_ALLOC, 0, 0);
      send_one(ffa_pkg::MODE_ALLOC, 0, 1);
      send_one(ffa_pkg::MODE_ALLOC, 0, 8);
      send_one(ffa_pkg::MODE_ALLOC, 0, 65535);
      send_one(ffa_pkg::MODE_FREE, 0, 0);
      send_one(ffa_pkg::MODE_NONE, 4095, 65535);
      send_one(ffa_pkg::MODE_ALLOC, 4095, 64);
      a = live_blocks[live_blocks.size() - 1];
      send_one(ffa_pkg::MODE_REALLOC, a, 8);
      send_one(ffa_pkg::MODE_REALLOC, a, 200);
      send_one(ffa_pkg::MODE_ALLOC, 0, 16);
      send_one(ffa_pkg::MODE_REALLOC, 0, 24);
      a = live_blocks[live_blocks.size() - 1];
      send_one(ffa_pkg::MODE_REALLOC, a, 0);
      send_one(ffa_pkg::MODE_FREE, a, 0);
      send_one(ffa_pkg::MODE_REALLOC, 0, 0);
      send_one(ffa_pkg::MODE_ALLOC, 0, 65535);
      // random phases with several heap limits
      write_limit(8191);
      run_random(450, 25);
      // heavy frees to overflow the list
      run_random(320, 85);
      write_limit(1);
      run_random(250, 25);
      write_limit(brk_q + 150);
      run_random(350, 25);
      write_limit(HEAP);
      run_random(500, 30);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("tb_first_fit_free_list_allocator passed");
      else
         $display("tb_first_fit_free_list_allocator failed");
      $finish;
   end

   initial begin
      #40000000;
      $display("tb_first_fit_free_list_allocator failed");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_stream_if.sv
hw/rtl/ffa_size_ram.sv
hw/rtl/ffa_list_ram.sv
hw/rtl/first_fit_free_list_allocator.sv
hw/rtl/ffa_checker.sv
bench/tb_first_fit_free_list_allocator.sv
